### sv/assert_macros.svh
// Assertion macros for the projection core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define CLP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/clp_pkg.sv
// Shared widths, types, reset values and helpers for the lens projection core.
package clp_pkg;

  localparam int COORD_BITS     = 21;
  localparam int COORD_FRAC     = 8;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_W         = AXIS_FRAC_BITS + 2;
  localparam int D_W            = COORD_BITS + 1;
  localparam int P_W            = AXIS_W + D_W;
  localparam int U_W            = P_W + 2;
  localparam int SQ_W           = 2 * D_W;
  localparam int S_W            = SQ_W + 2;
  localparam int R_W            = S_W + 2 * AXIS_FRAC_BITS;
  localparam int N_W            = (R_W + 1) / 2;
  localparam int DEN_W          = (N_W > U_W ? N_W : U_W) + 1;
  localparam int DD_W           = DEN_W + 1;
  localparam int A_W            = COORD_BITS + 1;
  localparam int NUM_W          = A_W + U_W;
  localparam int Q_W            = COORD_BITS;
  localparam int CMP_W          = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int VP_W           = 3 * COORD_BITS;
  localparam int AX_REG_W       = 3 * AXIS_W;
  localparam int CFG_W          = (VP_W > AX_REG_W) ? VP_W : AX_REG_W;
  localparam int CFG_IDX_W      = 3;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;

  typedef enum logic [1:0] {
    LENS_PERSP   = 2'd0,
    LENS_ORTHO   = 2'd1,
    LENS_FISHEYE = 2'd2,
    LENS_BUBBLE  = 2'd3
  } lens_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENS  = 3'd0,
    CFG_RIGHT = 3'd1,
    CFG_UP    = 3'd2,
    CFG_VIEW  = 3'd3,
    CFG_VP    = 3'd4,
    CFG_FOCAL = 3'd5
  } cfg_idx_e;

  localparam logic [AXIS_W-1:0] AXIS_ONE     = AXIS_W'(1) << AXIS_FRAC_BITS;
  localparam logic [AXIS_W-1:0] AXIS_ZERO    = '0;
  localparam logic [AXIS_W-1:0] AXIS_RIGHT_Z = AXIS_W'(15) << (AXIS_FRAC_BITS - 4);
  localparam logic [AX_REG_W-1:0] RIGHT_RST  = {AXIS_ONE, AXIS_ZERO, AXIS_RIGHT_Z};
  localparam logic [AX_REG_W-1:0] UP_RST     = {AXIS_ZERO, AXIS_ONE, AXIS_ZERO};
  localparam logic [AX_REG_W-1:0] VIEW_RST   = {AXIS_ZERO, AXIS_ZERO, AXIS_ONE};
  localparam logic [COORD_BITS-1:0] FOCAL_RST = COORD_BITS'(1) << COORD_FRAC;

  // classified item handed from front to back
  typedef struct packed {
    lens_e                 mode;
    logic signed [U_W-1:0] u;
    logic signed [U_W-1:0] v;
    logic signed [U_W-1:0] w;
    logic [S_W-1:0]        s;
  } item_t;

  typedef struct packed {
    item_t          it;
    logic [R_W-1:0] rem;
    logic [N_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                  ortho;
    logic                  degen;
    logic                  flip;
    logic                  uneg;
    logic                  upos;
    logic                  vneg;
    logic                  vpos;
    logic [DEN_W-1:0]      den;
    logic [A_W-1:0]        a;
    logic [U_W-1:0]        umag;
    logic [U_W-1:0]        vmag;
    logic [COORD_BITS-1:0] ou;
    logic [COORD_BITS-1:0] ov;
  } pre_t;

  typedef struct packed {
    logic                  ortho;
    logic                  degen;
    logic                  flip;
    logic                  uneg;
    logic                  upos;
    logic                  vneg;
    logic                  vpos;
    logic [DEN_W-1:0]      den;
    logic [CMP_W-1:0]      remu;
    logic [CMP_W-1:0]      remv;
    logic [Q_W:0]          qu;
    logic [Q_W:0]          qv;
    logic [COORD_BITS-1:0] ou;
    logic [COORD_BITS-1:0] ov;
  } dv_t;

  // saturate a magnitude with sign to the signed coordinate range
  function automatic logic [COORD_BITS-1:0] sat_out(input logic neg, input logic big,
                                                    input logic [Q_W:0] m);
    logic [Q_W:0] maxp;
    maxp = (Q_W+1)'((1 << (COORD_BITS - 1)) - 1);
    if (neg) begin
      if (big || m > maxp + (Q_W+1)'(1)) return {1'b1, {(COORD_BITS-1){1'b0}}};
      return COORD_BITS'((Q_W+1)'(0) - m);
    end
    if (big || m > maxp) return {1'b0, {(COORD_BITS-1){1'b1}}};
    return m[COORD_BITS-1:0];
  endfunction

endpackage

### sv/clp_ifs.sv
// Point and screen channel interfaces of the projection core.
interface clp_point_if import clp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface clp_screen_if import clp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] screen_u;
  logic signed [COORD_BITS-1:0] screen_v;
  logic                         degenerate;
  modport source(output valid, screen_u, screen_v, degenerate, input ready);
  modport sink(input valid, screen_u, screen_v, degenerate, output ready);
endinterface

### sv/clp_front.sv
// Front pipeline: point minus viewpoint, axis dot products and squared length.
module clp_front import clp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  clp_point_if.sink           point_i,
  input  logic [AX_REG_W-1:0] right_axis_i,
  input  logic [AX_REG_W-1:0] up_axis_i,
  input  logic [AX_REG_W-1:0] view_axis_i,
  input  logic [VP_W-1:0]     viewpoint_i,
  input  lens_e               lens_i,
  input  logic                full_i,
  output logic                push_o,
  output item_t               item_o
);

  logic [2:0] v_q;
  logic       en;

  logic signed [COORD_BITS-1:0] pt [3];
  logic signed [COORD_BITS-1:0] vp [3];
  logic signed [AXIS_W-1:0]     ax [3][3];

  logic signed [D_W-1:0]  d_q [3];
  logic signed [P_W-1:0]  prod_q [3][3];
  logic signed [SQ_W-1:0] sq_q [3];
  item_t                  item_q;

  assign en            = !v_q[2] || !full_i;
  assign point_i.ready = en;
  assign push_o        = v_q[2] && !full_i;
  assign item_o        = item_q;

  always_comb begin
    pt[0] = point_i.point_x;
    pt[1] = point_i.point_y;
    pt[2] = point_i.point_z;
    for (int c = 0; c < 3; c++) begin
      vp[c]    = viewpoint_i[(3-c)*COORD_BITS-1 -: COORD_BITS];
      ax[0][c] = right_axis_i[(3-c)*AXIS_W-1 -: AXIS_W];
      ax[1][c] = up_axis_i[(3-c)*AXIS_W-1 -: AXIS_W];
      ax[2][c] = view_axis_i[(3-c)*AXIS_W-1 -: AXIS_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], point_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d_q[c]  <= {pt[c][COORD_BITS-1], pt[c]} - {vp[c][COORD_BITS-1], vp[c]};
        sq_q[c] <= d_q[c] * d_q[c];
        for (int a = 0; a < 3; a++) begin
          prod_q[a][c] <= ax[a][c] * d_q[c];
        end
      end
      item_q.mode <= lens_i;
      item_q.u    <= prod_q[0][0] + prod_q[0][1] + prod_q[0][2];
      item_q.v    <= prod_q[1][0] + prod_q[1][1] + prod_q[1][2];
      item_q.w    <= prod_q[2][0] + prod_q[2][1] + prod_q[2][2];
      item_q.s    <= S_W'(unsigned'(sq_q[0])) + S_W'(unsigned'(sq_q[1]))
                   + S_W'(unsigned'(sq_q[2]));
    end
  end

endmodule

### sv/clp_fifo.sv
// Short queue of classified items between front and back.
module clp_fifo import clp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output item_t data_o,
  output logic  full_o,
  output logic  valid_o
);

  `include "assert_macros.svh"

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0]   count_q;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  `CLP_ASSERT(a_count_range, count_q <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count overrun")
  `CLP_ASSERT_NEVER(a_pop_empty, pop_i && count_q == '0, "pop from empty queue")
  `CLP_ASSERT(a_push_count, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1,
              "queue count did not follow push")

endmodule

### sv/clp_back.sv
// Back pipeline: square root, divisor select, scaling and restoring divide.
module clp_back import clp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 item_i,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  logic [COORD_BITS-1:0] focal_i,
  clp_screen_if.source          screen_o
);

  logic en;
  logic out_valid_q;

  logic [N_W:0]   sqv_q;
  sq_t            sq_q [N_W+1];
  logic           pre_v_q;
  pre_t           pre_q;
  logic [Q_W+1:0] dvv_q;
  dv_t            dv_q [Q_W+2];

  logic [COORD_BITS-1:0] su_q, sv_q;
  logic                  degen_q;

  assign en               = !out_valid_q || screen_o.ready;
  assign item_pop_o       = en && item_valid_i;
  assign screen_o.valid      = out_valid_q;
  assign screen_o.screen_u   = su_q;
  assign screen_o.screen_v   = sv_q;
  assign screen_o.degenerate = degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q       <= '0;
      pre_v_q     <= 1'b0;
      dvv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sqv_q       <= {sqv_q[N_W-1:0], item_valid_i};
      pre_v_q     <= sqv_q[N_W];
      dvv_q       <= {dvv_q[Q_W:0], pre_v_q};
      out_valid_q <= dvv_q[Q_W+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].it   <= item_i;
      sq_q[0].rem  <= R_W'(item_i.s) << (2 * AXIS_FRAC_BITS);
      sq_q[0].root <= '0;
    end
  end

  // one root bit per stage
  for (genvar g = 0; g < N_W; g++) begin : g_sqrt
    localparam int B = N_W - 1 - g;
    logic [R_W:0] cand;
    sq_t          nx;
    always_comb begin
      cand = ((R_W+1)'(sq_q[g].root) << (B + 1)) | ((R_W+1)'(1) << (2 * B));
      nx   = sq_q[g];
      if ({1'b0, sq_q[g].rem} >= cand) begin
        nx.rem     = R_W'({1'b0, sq_q[g].rem} - cand);
        nx.root[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[g+1] <= nx;
    end
  end

  // divisor and numerator factor per lens
  pre_t                  pre_d;
  logic [DD_W-1:0]       dd;
  logic [U_W-1:0]        wmag;
  logic [U_W:0]          omu, omv;
  item_t                 it_l;
  logic [N_W-1:0]        n_l;

  always_comb begin
    it_l       = sq_q[N_W].it;
    n_l        = sq_q[N_W].root;
    pre_d      = '0;
    pre_d.uneg = it_l.u[U_W-1];
    pre_d.vneg = it_l.v[U_W-1];
    pre_d.upos = !it_l.u[U_W-1] && (it_l.u != '0);
    pre_d.vpos = !it_l.v[U_W-1] && (it_l.v != '0);
    pre_d.umag = it_l.u[U_W-1] ? U_W'(-it_l.u) : U_W'(it_l.u);
    pre_d.vmag = it_l.v[U_W-1] ? U_W'(-it_l.v) : U_W'(it_l.v);
    wmag       = it_l.w[U_W-1] ? U_W'(-it_l.w) : U_W'(it_l.w);
    dd         = {{(DD_W-N_W){1'b0}}, n_l} - {{(DD_W-U_W){it_l.w[U_W-1]}}, it_l.w};
    pre_d.a    = {1'b0, focal_i};
    unique case (it_l.mode)
      LENS_PERSP:   pre_d.den = DEN_W'(wmag);
      LENS_ORTHO:   pre_d.ortho = 1'b1;
      LENS_FISHEYE: pre_d.den = DEN_W'(n_l);
      LENS_BUBBLE: begin
        pre_d.den  = dd[DD_W-1] ? DEN_W'(-dd) : DEN_W'(dd);
        pre_d.flip = dd[DD_W-1];
        pre_d.a    = {focal_i, 1'b0};
      end
      default: pre_d.ortho = 1'b0;
    endcase
    pre_d.degen = !pre_d.ortho && (pre_d.den == '0);
    omu = ((U_W+1)'(pre_d.umag) + ((U_W+1)'(1) << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
    omv = ((U_W+1)'(pre_d.vmag) + ((U_W+1)'(1) << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
    pre_d.ou = sat_out(pre_d.uneg, |omu[U_W:Q_W+1], omu[Q_W:0]);
    pre_d.ov = sat_out(pre_d.vneg, |omv[U_W:Q_W+1], omv[Q_W:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) pre_q <= pre_d;
  end

  // scaled numerators
  logic [NUM_W-1:0] numu, numv;
  dv_t              mul_d;

  always_comb begin
    numu       = pre_q.a * pre_q.umag;
    numv       = pre_q.a * pre_q.vmag;
    mul_d      = '0;
    mul_d.ortho = pre_q.ortho;
    mul_d.degen = pre_q.degen;
    mul_d.flip  = pre_q.flip;
    mul_d.uneg  = pre_q.uneg;
    mul_d.upos  = pre_q.upos;
    mul_d.vneg  = pre_q.vneg;
    mul_d.vpos  = pre_q.vpos;
    mul_d.den   = pre_q.den;
    mul_d.remu  = CMP_W'(numu);
    mul_d.remv  = CMP_W'(numv);
    mul_d.ou    = pre_q.ou;
    mul_d.ov    = pre_q.ov;
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= mul_d;
  end

  // top quotient bit flags overflow, then one bit per stage
  for (genvar j = 0; j <= Q_W; j++) begin : g_div
    localparam int K = Q_W - j;
    logic [CMP_W-1:0] shd;
    dv_t              nx;
    always_comb begin
      shd = CMP_W'(dv_q[j].den) << K;
      nx  = dv_q[j];
      if (dv_q[j].remu >= shd) begin
        nx.remu  = dv_q[j].remu - shd;
        nx.qu[K] = 1'b1;
      end
      if (dv_q[j].remv >= shd) begin
        nx.remv  = dv_q[j].remv - shd;
        nx.qv[K] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[j+1] <= nx;
    end
  end

  // round half away, apply sign, saturate
  dv_t                   last;
  logic                  rndu, rndv;
  logic [Q_W:0]          mu, mv;
  logic [COORD_BITS-1:0] su_d, sv_d;

  always_comb begin
    last = dv_q[Q_W+1];
    rndu = ({1'b0, last.remu} << 1) >= (CMP_W+1)'(last.den);
    rndv = ({1'b0, last.remv} << 1) >= (CMP_W+1)'(last.den);
    mu   = {1'b0, last.qu[Q_W-1:0]} + (Q_W+1)'(rndu);
    mv   = {1'b0, last.qv[Q_W-1:0]} + (Q_W+1)'(rndv);
    if (last.ortho) begin
      su_d = last.ou;
      sv_d = last.ov;
    end else if (last.degen) begin
      su_d = last.upos ? sat_out(1'b0, 1'b1, '0) : last.uneg ? sat_out(1'b1, 1'b1, '0) : '0;
      sv_d = last.vpos ? sat_out(1'b0, 1'b1, '0) : last.vneg ? sat_out(1'b1, 1'b1, '0) : '0;
    end else begin
      su_d = sat_out(last.uneg ^ last.flip, last.qu[Q_W], mu);
      sv_d = sat_out(last.vneg ^ last.flip, last.qv[Q_W], mv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      su_q    <= su_d;
      sv_q    <= sv_d;
      degen_q <= last.degen;
    end
  end

endmodule

### sv/camera_lens_projection_core.sv
// Lens projection core: maps one 3D Q12.8 point per beat to 2D screen coordinates.
// Usage:
//   point_i  : input beats carry point_x/y/z, taken when valid and ready are high.
//   screen_o : result beats carry screen_u/v and degenerate, one per input beat,
//              in input order.
//   cfg_*    : register writes (index 0 lens, 1-3 axes, 4 viewpoint, 5 focal),
//              only while no beat is in flight.
// Throughput is one point per cycle while the receiver keeps ready high and the
// queue is not full. The beat passes 67 register stages, the first loaded at the
// accepting edge: 3 front stages, the queue, the root entry register, a 37-step
// pipelined square root, divisor select, one multiply stage, 22 restoring divide
// stages and the output register.
// A stalled receiver freezes the back pipeline; the front keeps filling the
// four-entry queue and drops ready only once the queue is full.
// Reset empties all pipelines and loads the default camera: perspective lens,
// the default axes and a focal distance of one.
module camera_lens_projection_core import clp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  clp_point_if.sink            point_i,
  clp_screen_if.source         screen_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  lens_e                 lens_q;
  logic [AX_REG_W-1:0]   right_q, up_q, view_q;
  logic [VP_W-1:0]       vp_q;
  logic [COORD_BITS-1:0] focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lens_q  <= LENS_PERSP;
      right_q <= RIGHT_RST;
      up_q    <= UP_RST;
      view_q  <= VIEW_RST;
      vp_q    <= '0;
      focal_q <= FOCAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LENS:  lens_q  <= lens_e'(cfg_data_i[1:0]);
        CFG_RIGHT: right_q <= cfg_data_i[AX_REG_W-1:0];
        CFG_UP:    up_q    <= cfg_data_i[AX_REG_W-1:0];
        CFG_VIEW:  view_q  <= cfg_data_i[AX_REG_W-1:0];
        CFG_VP:    vp_q    <= cfg_data_i[VP_W-1:0];
        CFG_FOCAL: focal_q <= cfg_data_i[COORD_BITS-1:0];
        default:   lens_q  <= lens_q;
      endcase
    end
  end

  logic  push, full, pop, q_valid;
  item_t f_item, q_item;

  clp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .point_i      (point_i),
    .right_axis_i (right_q),
    .up_axis_i    (up_q),
    .view_axis_i  (view_q),
    .viewpoint_i  (vp_q),
    .lens_i       (lens_q),
    .full_i       (full),
    .push_o       (push),
    .item_o       (f_item)
  );

  clp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .pop_i   (pop),
    .data_o  (q_item),
    .full_o  (full),
    .valid_o (q_valid)
  );

  clp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_pop_o   (pop),
    .focal_i      (focal_q),
    .screen_o     (screen_o)
  );

endmodule

### tb/clp_tb_checker.sv
// Checker for the lens projection core: mirrors the registers, predicts each screen beat, compares.
`timescale 1ns / 100ps
module clp_tb_checker import clp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  clp_point_if                 pt,
  clp_screen_if                scr,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   degen_seen_o
);

  typedef struct {
    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;
    logic                  degen;
  } screen_t;

  localparam logic [127:0] QUOT_CAP = 128'd1 << 62;
  localparam logic [127:0] COORD_MAX = (128'd1 << (COORD_BITS - 1)) - 1;

  logic [1:0]            lens_q;
  logic [AX_REG_W-1:0]   right_q, up_q, view_q;
  logic [VP_W-1:0]       vp_q;
  logic [COORD_BITS-1:0] focal_q;

  screen_t expected_q[$];

  function automatic logic [COORD_BITS-1:0] clamp_coord(input bit neg, input logic [127:0] m);
    if (neg) begin
      if (m > COORD_MAX + 1) return {1'b1, {(COORD_BITS-1){1'b0}}};
      return COORD_BITS'(128'd0 - m);
    end
    if (m > COORD_MAX) return COORD_MAX[COORD_BITS-1:0];
    return m[COORD_BITS-1:0];
  endfunction

  function automatic logic [127:0] mag(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // round(a*b/c) to nearest, ties away from zero, capped
  function automatic logic [127:0] scaled_quot(input logic [127:0] a, b, c);
    logic [127:0] p, q, r;
    p = a * b;
    q = p / c;
    r = p % c;
    if (q >= QUOT_CAP) return QUOT_CAP;
    if (r >= c - r) q = q + 1;
    return q;
  endfunction

  function automatic logic [127:0] int_root(input logic [127:0] s);
    logic [127:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic longint axis_dot(input logic [AX_REG_W-1:0] ax, input longint d[3]);
    return longint'($signed(ax[47:32])) * d[0] + longint'($signed(ax[31:16])) * d[1]
         + longint'($signed(ax[15:0])) * d[2];
  endfunction

  function automatic screen_t project_point(input logic signed [COORD_BITS-1:0] px, py, pz);
    screen_t      res;
    longint       d[3];
    longint       uu[2];
    longint       u3, dd;
    logic [127:0] den, a, s, n, m;
    bit           flip, degen;
    d[0] = longint'(px) - longint'($signed(vp_q[62:42]));
    d[1] = longint'(py) - longint'($signed(vp_q[41:21]));
    d[2] = longint'(pz) - longint'($signed(vp_q[20:0]));
    uu[0] = axis_dot(right_q, d);
    uu[1] = axis_dot(up_q, d);
    u3 = axis_dot(view_q, d);
    a = 128'(focal_q);
    flip = 0;
    if (lens_e'(lens_q) == LENS_ORTHO) begin
      res.u = clamp_coord(uu[0] < 0, (mag(uu[0]) + (128'd1 << (AXIS_FRAC_BITS-1))) >> AXIS_FRAC_BITS);
      res.v = clamp_coord(uu[1] < 0, (mag(uu[1]) + (128'd1 << (AXIS_FRAC_BITS-1))) >> AXIS_FRAC_BITS);
      res.degen = 0;
      return res;
    end
    if (lens_e'(lens_q) == LENS_PERSP) begin
      den = mag(u3);
    end else begin
      s = mag(d[0]) * mag(d[0]) + mag(d[1]) * mag(d[1]) + mag(d[2]) * mag(d[2]);
      n = int_root(s << (2 * AXIS_FRAC_BITS));
      if (lens_e'(lens_q) == LENS_FISHEYE) begin
        den = n;
      end else begin
        dd = longint'(n) - u3;
        den = mag(dd);
        flip = dd < 0;
        a = 128'(focal_q) * 2;
      end
    end
    degen = (den == 0);
    for (int i = 0; i < 2; i++) begin
      if (degen) m = (uu[i] == 0) ? 128'd0 : QUOT_CAP;
      else m = scaled_quot(a, mag(uu[i]), den);
      // saturation of a zero divisor follows the sign of the dot product alone
      if (i == 0) res.u = clamp_coord(degen ? (uu[i] < 0) : ((uu[i] < 0) != flip), m);
      else res.v = clamp_coord(degen ? (uu[i] < 0) : ((uu[i] < 0) != flip), m);
    end
    res.degen = degen;
    return res;
  endfunction

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    checked_o = 0;
    degen_seen_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    screen_t exp_beat;
    if (!rst_ni) begin
      lens_q  <= LENS_PERSP;
      right_q <= RIGHT_RST;
      up_q    <= UP_RST;
      view_q  <= VIEW_RST;
      vp_q    <= '0;
      focal_q <= FOCAL_RST;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (pt.valid && pt.ready)
        expected_q.push_back(project_point(pt.point_x, pt.point_y, pt.point_z));
      if (scr.valid && scr.ready) begin
        if (expected_q.size() == 0) begin
          report("screen beat with nothing expected");
        end else begin
          exp_beat = expected_q.pop_front();
          checked_o++;
          if (scr.degenerate) degen_seen_o++;
          if (scr.screen_u !== exp_beat.u)
            report($sformatf("screen_u %0d, want %0d", scr.screen_u, $signed(exp_beat.u)));
          if (scr.screen_v !== exp_beat.v)
            report($sformatf("screen_v %0d, want %0d", scr.screen_v, $signed(exp_beat.v)));
          if (scr.degenerate !== exp_beat.degen)
            report($sformatf("degenerate %b, want %b", scr.degenerate, exp_beat.degen));
        end
      end
      pending_o = expected_q.size();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LENS:  lens_q  <= cfg_data_i[1:0];
          CFG_RIGHT: right_q <= cfg_data_i[AX_REG_W-1:0];
          CFG_UP:    up_q    <= cfg_data_i[AX_REG_W-1:0];
          CFG_VIEW:  view_q  <= cfg_data_i[AX_REG_W-1:0];
          CFG_VP:    vp_q    <= cfg_data_i[VP_W-1:0];
          CFG_FOCAL: focal_q <= cfg_data_i[COORD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb_camera_lens_projection_core.sv
// Top of the lens projection core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_camera_lens_projection_core;
  import clp_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int NUM_PHASES   = 12;
  localparam int RAND_PER_PH  = 96;
  localparam int LONG_HOLD    = 400;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic clk_i = 0;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int  fail_count, pending, checked, degen_seen;
  int  idle_cycles;
  bit  long_hold;
  logic [VP_W-1:0] cur_vp;

  clp_point_if  pt();
  clp_screen_if scr();

  camera_lens_projection_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .point_i    (pt),
    .screen_o   (scr),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  clp_tb_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pt           (pt),
    .scr          (scr),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .degen_seen_o (degen_seen)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((pt.valid && pt.ready) || (scr.valid && scr.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(input logic signed [COORD_BITS-1:0] x, y, z);
    int g;
    g = pick_gap();
    if (g > 0) begin
      pt.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    pt.valid   <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    do @(posedge clk_i); while (!pt.ready);
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    pt.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] rand_wide();
    return CFG_W'({$urandom, $urandom});
  endfunction

  function automatic logic [AX_REG_W-1:0] rand_axis();
    logic [AXIS_W-1:0] c[3];
    int k;
    k = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) c[i] = AXIS_ZERO;
    c[k] = $urandom_range(0, 1) ? AXIS_ONE : AXIS_W'(0) - AXIS_ONE;
    return {c[0], c[1], c[2]};
  endfunction

  task automatic rand_point(output logic signed [COORD_BITS-1:0] x, y, z);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
      z = COORD_BITS'($urandom);
    end else if (kind < 9) begin
      x = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
      y = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
      z = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
    end else begin
      // close to the viewpoint, where divisors get small
      x = cur_vp[62:42] + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
      y = cur_vp[41:21] + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
      z = cur_vp[20:0] + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
    end
  endtask

  task automatic set_camera(input int ph);
    logic [CFG_W-1:0] rgt, upa, vw, vp, foc;
    case (ph / 4)
      0: begin
        rgt = CFG_W'(RIGHT_RST); upa = CFG_W'(UP_RST); vw = CFG_W'(VIEW_RST);
        vp = '0; foc = CFG_W'(FOCAL_RST);
      end
      1: begin
        rgt = $urandom_range(0, 1) ? CFG_W'(rand_axis()) : rand_wide();
        upa = $urandom_range(0, 1) ? CFG_W'(rand_axis()) : rand_wide();
        vw  = $urandom_range(0, 1) ? CFG_W'(rand_axis()) : rand_wide();
        vp  = $urandom_range(0, 1) ? rand_wide() : CFG_W'({3{COORD_BITS'($urandom_range(0, 4095))}});
        foc = $urandom_range(0, 1) ? rand_wide() : CFG_W'($urandom_range(1, 4096));
      end
      default: begin
        case (ph % 4)
          0: begin
            rgt = CFG_W'({3{16'h7fff}}); upa = CFG_W'({3{16'h7fff}}); vw = CFG_W'({3{16'h7fff}});
            vp = {1'b0, {3{CMAX}}}; foc = {CFG_W{1'b1}};
          end
          1: begin
            rgt = CFG_W'({3{16'h8000}}); upa = CFG_W'({3{16'h8000}}); vw = CFG_W'({3{16'h8000}});
            vp = {1'b0, {3{CMIN}}}; foc = CFG_W'(1);
          end
          2: begin
            rgt = CFG_W'(RIGHT_RST); upa = CFG_W'(UP_RST); vw = CFG_W'(VIEW_RST);
            vp = '0; foc = '0;
          end
          default: begin
            rgt = rand_wide(); upa = rand_wide(); vw = rand_wide();
            vp = rand_wide(); foc = rand_wide();
          end
        endcase
      end
    endcase
    cfg_write(CFG_LENS, CFG_W'(lens_e'(ph % 4)) | (rand_wide() & ~CFG_W'(3)));
    cfg_write(CFG_RIGHT, rgt);
    cfg_write(CFG_UP, upa);
    cfg_write(CFG_VIEW, vw);
    cfg_write(CFG_VP, vp);
    cfg_write(CFG_FOCAL, foc);
    // indexes past the register list must leave everything untouched
    if (ph == NUM_PHASES - 1) begin
      cfg_write(cfg_idx_e'(3'd6), rand_wide());
      cfg_write(cfg_idx_e'(3'd7), rand_wide());
    end
    cfg_we <= 1'b0;
    cur_vp = vp[VP_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic receiver();
    int g, run;
    forever begin
      if (long_hold) begin
        scr.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold = 0;
      end
      g = pick_gap();
      if (g > 0) begin
        scr.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      scr.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(negedge clk_i);
    end
  endtask

  initial begin
    logic signed [COORD_BITS-1:0] x, y, z;
    rst_ni     = 1'b0;
    pt.valid   = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    scr.ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_LENS;
    cfg_data   = '0;
    idle_cycles = 0;
    long_hold  = 0;
    cur_vp     = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    fork
      receiver();
    join_none

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_camera(ph);
      if (ph < 4) begin
        // origin, along and against the view axis, off-axis, field extremes
        send_point('0, '0, '0);
        send_point('0, '0, COORD_BITS'(256));
        send_point('0, '0, COORD_BITS'(-256));
        send_point(COORD_BITS'(256), COORD_BITS'(-256), '0);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
      end
      if (ph == 5) long_hold = 1;
      for (int i = 0; i < RAND_PER_PH; i++) begin
        rand_point(x, y, z);
        send_point(x, y, z);
      end
      stop_sending();
      wait_drained();
    end

    repeat (80) @(negedge clk_i);
    $display("Covered %0d projected points over %0d camera settings, all four lens modes,",
             checked, NUM_PHASES);
    $display("%0d of them degenerate, with random stalls on both channels.", degen_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending != 0) $display("%0d screen beats never arrived", pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
